// File: rtl/srm_pkg.sv
// Shared types, constants and helper functions for the smooth random modulator.
// Used by every module in rtl/; depends on nothing else.
package srm_pkg;

	localparam int TRK_W = 3;
	localparam int LEN_W = 24;
	localparam int RND_W = 16;
	localparam int LVL_W = 16;
	localparam int OUT_W = 17;
	localparam int FRAC_BITS = 16;
	localparam int STEP_W = 4;
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;

	// Register indexes on the APB port (byte address / 4)
	localparam logic [1:0] REG_MAGNET_POINT = 2'd0;
	localparam logic [1:0] REG_MAGNET_STRENGTH = 2'd1;
	localparam logic [1:0] REG_BIPOLAR_MODE = 2'd2;

	localparam logic [1:0] MAG_LOWER = 2'd0;
	localparam logic [1:0] MAG_MIDDLE = 2'd1;
	localparam logic [1:0] STR_WEAK = 2'd0;
	localparam logic [1:0] STR_AVERAGE = 2'd1;

	localparam logic [17:0] SMOOTH_K = 18'h30000;
	localparam logic signed [34:0] ROUND_HALF = 35'sd32768;
	localparam logic signed [16:0] BIPOLAR_OFS = 17'sd32768;

	typedef struct packed {
		logic [1:0] magnet_point;
		logic [1:0] magnet_strength;
		logic bipolar_mode;
	} srm_cfg_t;

	typedef struct packed {
		logic [TRK_W-1:0] trk;
		logic [LEN_W-1:0] len;
		logic [RND_W-1:0] rnd;
		logic in_range;
	} srm_item_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_TGT_MUL,
		BK_TGT_ADD,
		BK_DIV,
		BK_SQ,
		BK_CUBE,
		BK_MIX_MUL,
		BK_MIX_ADD,
		BK_OUT
	} bk_state_t;

	function automatic logic signed [17:0] magnet_q16(input logic [1:0] code);
		logic signed [17:0] m;
		case (code)
			MAG_LOWER: m = 18'sd0;
			MAG_MIDDLE: m = 18'sd32768;
			default: m = 18'sd65536;
		endcase
		return m;
	endfunction

	function automatic logic signed [16:0] strength_q16(input logic [1:0] code);
		logic signed [16:0] f;
		case (code)
			STR_WEAK: f = 17'sd19661;
			STR_AVERAGE: f = 17'sd32768;
			default: f = 17'sd45875;
		endcase
		return f;
	endfunction

	function automatic logic [LVL_W-1:0] clamp_level(input logic signed [19:0] x);
		logic [LVL_W-1:0] r;
		if (x < 20'sd0) begin
			r = '0;
		end else if (x > 20'sd65535) begin
			r = '1;
		end else begin
			r = x[LVL_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/srm_front.sv
// Front end: takes input ticks, maps a zero length to one and flags out-of-range tracks.
// Depends on srm_pkg; feeds srm_queue.
module srm_front #(
	parameter int TRACKS = 7
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [srm_pkg::TRK_W-1:0] track_index,
	input logic [srm_pkg::LEN_W-1:0] segment_samples,
	input logic [srm_pkg::RND_W-1:0] random_value,
	output logic push,
	output srm_pkg::srm_item_t push_item,
	input logic q_full
);
	import srm_pkg::*;

	logic fe_valid_s1;
	srm_item_t fe_item_s1;
	srm_item_t item_d;
	logic accept;

	assign in_stall = fe_valid_s1 & q_full;
	assign accept = in_valid & ~in_stall;
	assign push = fe_valid_s1;
	assign push_item = fe_item_s1;

	always_comb begin
		item_d.trk = track_index;
		item_d.len = (segment_samples == '0) ? LEN_W'(1) : segment_samples;
		item_d.rnd = random_value;
		item_d.in_range = ({2'b00, track_index} < 5'(TRACKS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_valid_s1 <= 1'b0;
		end else begin
			fe_valid_s1 <= accept | (fe_valid_s1 & q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fe_item_s1 <= item_d;
		end
	end

endmodule

// File: rtl/srm_queue.sv
// Short FIFO of classified ticks between the front end and the back end.
// Depends on srm_pkg.
module srm_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input srm_pkg::srm_item_t push_item,
	output logic full,
	input logic pop,
	output logic q_valid,
	output srm_pkg::srm_item_t q_item
);
	import srm_pkg::*;

	srm_item_t entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item = entry_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop = pop & q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push & ~do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop & ~do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: rtl/srm_back.sv
// Back end: per-track state, target draw, bit-serial progress divider,
// smoothstep and glide, and the output register. Depends on srm_pkg.
module srm_back #(
	parameter int TRACKS = 7,
	parameter int COUNT_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input srm_pkg::srm_cfg_t cfg,
	input logic q_valid,
	input srm_pkg::srm_item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input logic out_stall,
	output logic [srm_pkg::TRK_W-1:0] track_out,
	output logic signed [srm_pkg::OUT_W-1:0] level,
	output logic new_segment
);
	import srm_pkg::*;

	localparam int TIDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

	bk_state_t state_q, state_d;

	logic [COUNT_BITS-1:0] cnt_mem_q [TRACKS];
	logic [LVL_W-1:0] start_mem_q [TRACKS];
	logic [LVL_W-1:0] target_mem_q [TRACKS];

	srm_item_t item_q;
	logic [TIDX_W-1:0] idx_q;
	logic draw_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [LVL_W-1:0] st_q;
	logic [LVL_W-1:0] tg_q;
	logic signed [34:0] tprod_q;
	logic [LEN_W-1:0] rem_q;
	logic int_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [STEP_W-1:0] step_q;
	logic [33:0] pp_q;
	logic [16:0] s_q;
	logic signed [34:0] mprod_q;
	logic signed [OUT_W-1:0] lvl_q;
	logic out_valid_q;
	logic [TRK_W-1:0] track_out_q;
	logic signed [OUT_W-1:0] level_q;
	logic new_segment_q;

	logic [TIDX_W-1:0] rd_idx;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [LVL_W-1:0] rd_st;
	logic [LVL_W-1:0] rd_tg;
	logic rd_draw;
	logic signed [17:0] mdiff;
	logic signed [34:0] tprod_d;
	logic signed [34:0] tround;
	logic signed [19:0] tsum;
	logic [LVL_W-1:0] new_tg;
	logic [COUNT_BITS-1:0] cnt_next;
	logic div_int;
	logic [LEN_W:0] rem_sh;
	logic rem_ge;
	logic [LEN_W:0] rem_sub;
	logic [16:0] p;
	logic [17:0] wgt;
	logic [51:0] cube;
	logic signed [16:0] diff;
	logic signed [34:0] mprod_d;
	logic signed [34:0] mround;
	logic signed [19:0] msum;
	logic [LVL_W-1:0] v;
	logic signed [OUT_W-1:0] lvl_d;
	logic out_free;

	assign out_valid = out_valid_q;
	assign track_out = track_out_q;
	assign level = level_q;
	assign new_segment = new_segment_q;
	assign out_free = ~out_valid_q | ~out_stall;

	// State lookup for the item at the head of the queue
	assign rd_idx = TIDX_W'(q_item.trk);
	assign rd_cnt = cnt_mem_q[rd_idx];
	assign rd_st = start_mem_q[rd_idx];
	assign rd_tg = target_mem_q[rd_idx];
	assign rd_draw = (CMP_W'(rd_cnt) > CMP_W'(q_item.len)) || (rd_cnt == '1);

	// New target: random value pulled toward the magnet
	assign mdiff = magnet_q16(cfg.magnet_point) - $signed({2'b00, item_q.rnd});
	assign tprod_d = strength_q16(cfg.magnet_strength) * mdiff;
	assign tround = (tprod_q + ROUND_HALF) >>> 16;
	assign tsum = $signed({4'b0000, item_q.rnd}) + $signed(tround[19:0]);
	assign new_tg = draw_q ? clamp_level(tsum) : tg_q;
	assign cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

	// Counter never exceeds the length here, so the integer part is 0 or 1
	assign div_int = (CMP_W'(cnt_q) == CMP_W'(item_q.len));
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, item_q.len});
	assign rem_sub = rem_sh - {1'b0, item_q.len};
	assign p = {int_q, frac_q};

	assign wgt = SMOOTH_K - {p, 1'b0};
	assign cube = 52'(pp_q) * 52'(wgt);

	assign diff = $signed({1'b0, tg_q}) - $signed({1'b0, st_q});
	assign mprod_d = $signed({1'b0, s_q}) * diff;
	assign mround = (mprod_q + ROUND_HALF) >>> 16;
	assign msum = $signed({4'b0000, st_q}) + $signed(mround[19:0]);
	assign v = clamp_level(msum);
	assign lvl_d = cfg.bipolar_mode ? $signed({1'b0, v}) - BIPOLAR_OFS : $signed({1'b0, v});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop = q_valid;
				if (q_valid) begin
					state_d = q_item.in_range ? BK_TGT_MUL : BK_OUT;
				end
			end
			BK_TGT_MUL: state_d = BK_TGT_ADD;
			BK_TGT_ADD: state_d = BK_DIV;
			BK_DIV: begin
				if (step_q == STEP_W'(FRAC_BITS - 1)) begin
					state_d = BK_SQ;
				end
			end
			BK_SQ: state_d = BK_CUBE;
			BK_CUBE: state_d = BK_MIX_MUL;
			BK_MIX_MUL: state_d = BK_MIX_ADD;
			BK_MIX_ADD: state_d = BK_OUT;
			BK_OUT: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Per-track state, divider step count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TRACKS; t++) begin
				cnt_mem_q[t] <= '0;
				start_mem_q[t] <= '0;
				target_mem_q[t] <= '0;
			end
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_TGT_ADD) begin
				cnt_mem_q[idx_q] <= cnt_next;
				start_mem_q[idx_q] <= st_q;
				target_mem_q[idx_q] <= new_tg;
				step_q <= '0;
			end else if (state_q == BK_DIV) begin
				step_q <= step_q + 1'b1;
			end
			if ((state_q == BK_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					item_q <= q_item;
					idx_q <= rd_idx;
					draw_q <= q_item.in_range & rd_draw;
					cnt_q <= rd_draw ? '0 : rd_cnt;
					st_q <= rd_draw ? rd_tg : rd_st;
					tg_q <= rd_tg;
					lvl_q <= '0;
				end
			end
			BK_TGT_MUL: tprod_q <= tprod_d;
			BK_TGT_ADD: begin
				tg_q <= new_tg;
				int_q <= div_int;
				rem_q <= div_int ? '0 : LEN_W'(cnt_q);
				frac_q <= '0;
			end
			BK_DIV: begin
				rem_q <= rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
				frac_q <= {frac_q[FRAC_BITS-2:0], rem_ge};
			end
			BK_SQ: pp_q <= 34'(p) * 34'(p);
			BK_CUBE: s_q <= cube[48:32];
			BK_MIX_MUL: mprod_q <= mprod_d;
			BK_MIX_ADD: lvl_q <= lvl_d;
			BK_OUT: begin
				if (out_free) begin
					track_out_q <= item_q.trk;
					level_q <= lvl_q;
					new_segment_q <= draw_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/smooth_random_modulator_core.sv
// Top level of the smooth random modulator: APB register file, front end,
// tick queue and back end. Depends on srm_pkg, srm_front, srm_queue, srm_back.
//
// Usage: each input transfer (in_valid high, in_stall low) is one sample tick for
// one track, carrying track_index, segment_samples and random_value. Each tick
// gives exactly one output transfer: track_out, the glided level and new_segment.
// Tracks at or above TRACKS change no state and return level 0.
// The back end takes an in-range tick through state fetch, the target draw
// (multiply, add), the one-bit-per-cycle progress divider, smoothstep and glide
// (square, cube, mix multiply, mix add) and the output register, and takes no
// new tick until it is done; an out-of-range tick goes from the state fetch
// straight to the output register.
// A two-entry queue and a front register take up to three ticks while the back
// end works or out_stall is held; in_stall rises when they are full. A result
// held by out_stall stays stable; the back end waits before loading another.
// Reset clears all track counters and levels and the three registers to zero.
// Registers: 0x0 magnet_point, 0x4 magnet_strength, 0x8 bipolar_mode.
module smooth_random_modulator_core #(
	parameter int TRACKS = 7,
	parameter int COUNT_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [srm_pkg::TRK_W-1:0] track_index,
	input logic [srm_pkg::LEN_W-1:0] segment_samples,
	input logic [srm_pkg::RND_W-1:0] random_value,
	output logic out_valid,
	input logic out_stall,
	output logic [srm_pkg::TRK_W-1:0] track_out,
	output logic signed [srm_pkg::OUT_W-1:0] level,
	output logic new_segment,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import srm_pkg::*;

	srm_cfg_t cfg_q;
	logic [1:0] reg_idx;
	logic cfg_wr;
	logic push;
	srm_item_t push_item;
	logic q_full;
	logic q_pop;
	logic q_valid;
	srm_item_t q_item;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MAGNET_POINT: cfg_q.magnet_point <= pwdata[1:0];
				REG_MAGNET_STRENGTH: cfg_q.magnet_strength <= pwdata[1:0];
				REG_BIPOLAR_MODE: cfg_q.bipolar_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_MAGNET_POINT: prdata = {30'd0, cfg_q.magnet_point};
			REG_MAGNET_STRENGTH: prdata = {30'd0, cfg_q.magnet_strength};
			REG_BIPOLAR_MODE: prdata = {31'd0, cfg_q.bipolar_mode};
			default: prdata = '0;
		endcase
	end

	srm_front #(
		.TRACKS(TRACKS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.track_index(track_index),
		.segment_samples(segment_samples),
		.random_value(random_value),
		.push(push),
		.push_item(push_item),
		.q_full(q_full)
	);

	srm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(q_full),
		.pop(q_pop),
		.q_valid(q_valid),
		.q_item(q_item)
	);

	srm_back #(
		.TRACKS(TRACKS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.track_out(track_out),
		.level(level),
		.new_segment(new_segment)
	);

`ifndef SYNTHESIS
	// A new segment is only ever drawn for a real track
	a_new_seg_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && new_segment) |-> ({2'b00, track_out} < 5'(TRACKS)))
		else $error("new segment reported for out-of-range track");

	// Out-of-range ticks return a zero level whatever the output mode
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ({2'b00, track_out} >= 5'(TRACKS))) |-> (level == '0 && !new_segment))
		else $error("out-of-range track gave a non-zero result");

	// Unipolar levels are never negative
	a_unipolar_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !cfg_q.bipolar_mode) |-> !level[OUT_W-1])
		else $error("negative level in unipolar mode");
`endif

endmodule

// File: dv/tb_smooth_random_modulator_core.sv
// Self-checking testbench for smooth_random_modulator_core: random sample ticks with
// random idling, a per-track glide predictor and in-order result checks.
// Depends on rtl/srm_pkg.sv and the core RTL.
`timescale 1ns / 1ps

module tb_smooth_random_modulator_core;
	import srm_pkg::*;

	localparam int TRACKS = 7;
	localparam int COUNT_BITS = 24;
	localparam longint COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_TICKS = 175;
	localparam int LONG_HOLD = 400;

	localparam logic [1:0] MAG_UPPER = 2'd2;
	localparam logic [1:0] MAG_ALIAS_UPPER = 2'd3;
	localparam logic [1:0] STR_STRONG = 2'd2;
	localparam logic [1:0] STR_ALIAS_STRONG = 2'd3;
	localparam logic UNIPOLAR = 1'b0;
	localparam logic BIPOLAR = 1'b1;

	typedef struct packed {
		logic [TRK_W-1:0] trk;
		logic [OUT_W-1:0] lvl;
		logic seg;
	} tick_result_t;

	class glide_scoreboard;
		longint sample_count[TRACKS];
		longint from_level[TRACKS];
		longint to_level[TRACKS];
		logic [1:0] mag_code;
		logic [1:0] str_code;
		logic bip;
		tick_result_t expected_levels[$];
		int errors;

		function new();
			for (int t = 0; t < TRACKS; t++) begin
				sample_count[t] = 0;
				from_level[t] = 0;
				to_level[t] = 0;
			end
			mag_code = MAG_LOWER;
			str_code = STR_WEAK;
			bip = UNIPOLAR;
			errors = 0;
		endfunction

		function void set_config(logic [1:0] m, logic [1:0] s, logic b);
			mag_code = m;
			str_code = s;
			bip = b;
		endfunction

		function longint round_q16(longint prod);
			return (prod + 32768) >>> 16;
		endfunction

		function longint clamp16(longint x);
			if (x < 0)
				return 0;
			if (x > 65535)
				return 65535;
			return x;
		endfunction

		function longint magnet_level();
			case (mag_code)
				MAG_LOWER: return 0;
				MAG_MIDDLE: return 32768;
				default: return 65536;
			endcase
		endfunction

		function longint pull_q16();
			case (str_code)
				STR_WEAK: return 19661;
				STR_AVERAGE: return 32768;
				default: return 45875;
			endcase
		endfunction

		// Advance one track by one tick and queue the level it should give.
		function void note_tick(logic [TRK_W-1:0] trk, logic [LEN_W-1:0] len,
				logic [RND_W-1:0] rnd);
			longint span, cnt, p, s, v, lvl, r;
			tick_result_t res;
			res.trk = trk;
			res.lvl = '0;
			res.seg = 1'b0;
			if (trk < TRACKS) begin
				span = (len == 0) ? 1 : longint'(len);
				r = longint'(rnd);
				cnt = sample_count[trk];
				if (cnt > span || cnt == COUNT_MAX) begin
					cnt = 0;
					from_level[trk] = to_level[trk];
					to_level[trk] = clamp16(r + round_q16(pull_q16() * (magnet_level() - r)));
					res.seg = 1'b1;
				end
				p = (cnt << 16) / span;
				if (p > 65536)
					p = 65536;
				s = (p * p * (196608 - 2 * p)) >>> 32;
				v = clamp16(from_level[trk]
					+ round_q16(s * (to_level[trk] - from_level[trk])));
				if (cnt < COUNT_MAX)
					cnt++;
				sample_count[trk] = cnt;
				lvl = (bip == BIPOLAR) ? v - 32768 : v;
				res.lvl = lvl[OUT_W-1:0];
			end
			expected_levels.push_back(res);
		endfunction

		function void check_level(logic [TRK_W-1:0] trk, logic [OUT_W-1:0] lvl, logic seg);
			tick_result_t want;
			if (expected_levels.size() == 0) begin
				$error("unexpected result: track_out %0d level %0d", trk, $signed(lvl));
				errors++;
				return;
			end
			want = expected_levels.pop_front();
			if (trk !== want.trk) begin
				$error("track_out: expected %0d, got %0d", want.trk, trk);
				errors++;
			end
			if (lvl !== want.lvl) begin
				$error("level: expected %0d, got %0d", $signed(want.lvl), $signed(lvl));
				errors++;
			end
			if (seg !== want.seg) begin
				$error("new_segment: expected %0d, got %0d", want.seg, seg);
				errors++;
			end
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [TRK_W-1:0] track_index = '0;
	logic [LEN_W-1:0] segment_samples = '0;
	logic [RND_W-1:0] random_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [TRK_W-1:0] track_out;
	logic signed [OUT_W-1:0] level;
	logic new_segment;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	glide_scoreboard sb = new();
	bit calm = 1'b0;
	bit hold_off_req = 1'b0;
	int cycles = 0;

	smooth_random_modulator_core #(
		.TRACKS(TRACKS),
		.COUNT_BITS(COUNT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.track_index(track_index),
		.segment_samples(segment_samples),
		.random_value(random_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.track_out(track_out),
		.level(level),
		.new_segment(new_segment),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// Result side: check each transfer, stall in random bursts or one long hold.
	initial begin
		int seg_left;
		seg_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_level(track_out, level, new_segment);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				seg_left = LONG_HOLD;
				out_stall <= 1'b1;
			end else if (seg_left > 0) begin
				seg_left--;
			end else if (!calm && !out_stall && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				seg_left = $urandom_range(0, 15);
			end else begin
				out_stall <= 1'b0;
				seg_left = calm ? 0 : $urandom_range(0, 15);
			end
		end
	end

	task automatic apb_write(logic [1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(logic [1:0] m, logic [1:0] s, logic b);
		apb_write(REG_MAGNET_POINT, {30'd0, m});
		apb_write(REG_MAGNET_STRENGTH, {30'd0, s});
		apb_write(REG_BIPOLAR_MODE, {31'd0, b});
		sb.set_config(m, s, b);
	endtask

	task automatic send_tick(logic [TRK_W-1:0] trk, logic [LEN_W-1:0] len,
			logic [RND_W-1:0] rnd);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		track_index <= trk;
		segment_samples <= len;
		random_value <= rnd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_tick(trk, len, rnd);
	endtask

	// Drop valid after the last transfer and hold until every level is back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_ticks(int n);
		logic [TRK_W-1:0] trk;
		logic [LEN_W-1:0] len;
		logic [RND_W-1:0] rnd;
		for (int i = 0; i < n; i++) begin
			trk = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, TRACKS - 1));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: len = 24'($urandom_range(0, 6));
				6, 7: len = 24'($urandom_range(0, 300));
				8: len = 24'($urandom);
				default: len = 24'hFFFFFF - 24'($urandom_range(0, 3));
			endcase
			case ($urandom_range(0, 7))
				0: rnd = 16'h0000;
				1: rnd = 16'hFFFF;
				default: rnd = 16'($urandom);
			endcase
			send_tick(trk, len, rnd);
		end
		drain();
	endtask

	initial begin
		// drive reset low after time zero so the asynchronous reset sees an edge
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_setting(MAG_LOWER, STR_WEAK, UNIPOLAR);

		send_tick(3'd7, 24'd5, 16'hFFFF);
		send_tick(3'd7, 24'd0, 16'h0000);
		// zero length acts as one: the third tick draws a new target, then every second one
		send_tick(3'd0, 24'd0, 16'h0000);
		send_tick(3'd0, 24'd0, 16'hFFFF);
		send_tick(3'd0, 24'd0, 16'hFFFF);
		send_tick(3'd0, 24'd0, 16'h0000);
		for (int i = 0; i < 4; i++)
			send_tick(3'd1, 24'd1, 16'hFFFF);
		send_tick(3'd2, 24'hFFFFFF, 16'h5A5A);
		send_tick(3'd2, 24'hFFFFFF, 16'hA5A5);
		// shrink the length under the running count to force a draw
		for (int i = 0; i < 4; i++)
			send_tick(3'd3, 24'd200, 16'h1234);
		send_tick(3'd3, 24'd1, 16'h0000);
		for (int t = 4; t < TRACKS; t++) begin
			send_tick(3'(t), 24'd2, 16'h8000);
			send_tick(3'(t), 24'd2, 16'h0001);
			send_tick(3'(t), 24'd2, 16'hFFFE);
		end
		drain();
		random_ticks(PHASE_TICKS);

		apply_setting(MAG_MIDDLE, STR_AVERAGE, BIPOLAR);
		hold_off_req = 1'b1;
		random_ticks(PHASE_TICKS);
		apply_setting(MAG_UPPER, STR_STRONG, UNIPOLAR);
		random_ticks(PHASE_TICKS);
		apply_setting(MAG_ALIAS_UPPER, STR_ALIAS_STRONG, BIPOLAR);
		random_ticks(PHASE_TICKS);
		apply_setting(MAG_LOWER, STR_ALIAS_STRONG, BIPOLAR);
		random_ticks(PHASE_TICKS);
		apply_setting(MAG_UPPER, STR_WEAK, UNIPOLAR);
		random_ticks(PHASE_TICKS);
		apply_setting(MAG_MIDDLE, STR_STRONG, UNIPOLAR);
		random_ticks(PHASE_TICKS);
		calm = 1'b1;
		apply_setting(MAG_ALIAS_UPPER, STR_AVERAGE, BIPOLAR);
		random_ticks(PHASE_TICKS);

		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
